>>> rtl/core/c2d_pkg.sv
// Shared constants, register codes and types for the 3x3 convolution stream block.
package c2d_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int KERNEL         = 3;

  localparam int PIX_IN_BITS    = 16;
  localparam int COEF_BITS      = 16;
  localparam int REG_BITS       = 48;
  localparam int FW_BITS        = 11;
  localparam int ROW_BITS       = 16;
  localparam int OUT_COL_BITS   = 10;
  localparam int VALUE_BITS     = 32;
  localparam int IN_DATA_BITS   = 16;
  localparam int OUT_DATA_BITS  = 64;
  localparam int OUT_PAD        = OUT_DATA_BITS - VALUE_BITS - ROW_BITS - OUT_COL_BITS;
  localparam int ROW_LSB        = VALUE_BITS;
  localparam int COL_LSB        = VALUE_BITS + ROW_BITS;

  localparam int WIDTH_RST      = 1024;
  localparam int HEIGHT_MIN     = 3;
  localparam int WIDTH_MIN      = 3;

  localparam int IDX_BITS       = 3;
  localparam logic [IDX_BITS-1:0] REG_COEF_TOP = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_COEF_MID = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_COEF_BOT = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_WIDTH    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_HEIGHT   = 3'd4;

  typedef struct packed {
    logic                    emit;
    logic                    last;
    logic                    border;
    logic [ROW_BITS-1:0]     row;
    logic [OUT_COL_BITS-1:0] col;
  } meta_t;

endpackage

>>> rtl/core/c2d_pos.sv
// Raster position counters and output position / border decode for each accepted pixel.
module c2d_pos #(
  parameter int MAX_WIDTH = c2d_pkg::MAX_WIDTH_DEF,
  parameter int COL_BITS  = $clog2(MAX_WIDTH),
  parameter int WB        = COL_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          acc,
  input  logic                          frame_start,
  input  logic [WB-1:0]                 width,
  input  logic [c2d_pkg::ROW_BITS-1:0]  height,
  output logic [COL_BITS-1:0]           cur_col,
  output c2d_pkg::meta_t                meta
);
  import c2d_pkg::*;

  logic [COL_BITS-1:0] in_col;
  logic [ROW_BITS-1:0] in_row;
  logic [COL_BITS-1:0] a_col;
  logic [ROW_BITS-1:0] a_row;

  logic [COL_BITS-1:0] col0;
  logic [ROW_BITS-1:0] row0;
  logic                wrap_col;
  logic [ROW_BITS:0]   row1;
  logic [ROW_BITS-1:0] cur_row;
  logic [WB-1:0]       col_inc;
  logic [ROW_BITS:0]   row_inc;
  logic [COL_BITS-1:0] in_col_next;
  logic [ROW_BITS-1:0] in_row_next;
  logic [WB-1:0]       ocol_full;
  logic [31:0]         ocol_ext;

  always_comb begin
    col0     = frame_start ? '0 : in_col;
    row0     = frame_start ? '0 : in_row;
    wrap_col = {1'b0, col0} >= width;
    cur_col  = wrap_col ? '0 : col0;
    row1     = {1'b0, row0} + (ROW_BITS+1)'(wrap_col);
    cur_row  = (row1 >= {1'b0, height}) ? '0 : row1[ROW_BITS-1:0];
    col_inc  = {1'b0, cur_col} + WB'(1);
    row_inc  = {1'b0, cur_row} + (ROW_BITS+1)'(1);
    if (col_inc >= width) begin
      in_col_next = '0;
      in_row_next = (row_inc >= {1'b0, height}) ? '0 : row_inc[ROW_BITS-1:0];
    end else begin
      in_col_next = col_inc[COL_BITS-1:0];
      in_row_next = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
    end else if (acc) begin
      in_col <= in_col_next;
      in_row <= in_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_col <= cur_col;
      a_row <= cur_row;
    end
  end

  always_comb begin
    if (a_col != '0) begin
      meta.row  = a_row - ROW_BITS'(1);
      ocol_full = {1'b0, a_col} - WB'(1);
    end else begin
      meta.row  = a_row - ROW_BITS'(2);
      ocol_full = width - WB'(1);
    end
    ocol_ext    = 32'(ocol_full);
    meta.col    = ocol_ext[OUT_COL_BITS-1:0];
    meta.emit   = (a_row >= ROW_BITS'(2)) || ((a_row == ROW_BITS'(1)) && (a_col != '0));
    meta.last   = (a_row == height - ROW_BITS'(1)) && ({1'b0, a_col} == width - WB'(1));
    meta.border = (meta.row == '0) || (ocol_full == '0) || (ocol_full == width - WB'(1));
  end

endmodule

>>> rtl/core/c2d_line_buf.sv
// Two-row line store: one word per column holding the two previous rows, with write bypass.
module c2d_line_buf #(
  parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = c2d_pkg::PIXEL_BITS_DEF,
  parameter int COL_BITS   = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         acc,
  input  logic [COL_BITS-1:0]          rd_addr,
  input  logic signed [PIXEL_BITS-1:0] pixel,
  input  logic                         a_valid,
  input  logic                         adv,
  output logic signed [PIXEL_BITS-1:0] col_top,
  output logic signed [PIXEL_BITS-1:0] col_mid,
  output logic signed [PIXEL_BITS-1:0] col_bot
);
  import c2d_pkg::*;

  localparam int WORD_BITS = 2 * PIXEL_BITS;

  logic [WORD_BITS-1:0]         mem [MAX_WIDTH];
  logic [WORD_BITS-1:0]         rd_data;
  logic [WORD_BITS-1:0]         byp_data;
  logic                         byp;
  logic [COL_BITS-1:0]          a_addr;
  logic signed [PIXEL_BITS-1:0] a_px;
  logic [WORD_BITS-1:0]         eff;
  logic [WORD_BITS-1:0]         wr_word;
  logic                         wr_en;

  assign wr_en   = a_valid && adv;
  assign eff     = byp ? byp_data : rd_data;
  assign col_top = eff[WORD_BITS-1:PIXEL_BITS];
  assign col_mid = eff[PIXEL_BITS-1:0];
  assign col_bot = a_px;
  assign wr_word = {col_mid, a_px};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[a_addr] <= wr_word;
    end
    if (acc) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_addr   <= rd_addr;
      a_px     <= pixel;
      byp_data <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (acc) begin
      byp <= wr_en && (rd_addr == a_addr);
    end
  end

  a_byp_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(byp) |-> $past(wr_en))
    else $error("bypass taken without a write to the same column");

endmodule

>>> rtl/core/c2d_mac.sv
// 3x3 window registers, coefficient products and registered adder tree.
module c2d_mac #(
  parameter int PIXEL_BITS = c2d_pkg::PIXEL_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                win_en,
  input  logic                                                adv,
  input  logic signed [PIXEL_BITS-1:0]                        col_top,
  input  logic signed [PIXEL_BITS-1:0]                        col_mid,
  input  logic signed [PIXEL_BITS-1:0]                        col_bot,
  input  logic [c2d_pkg::KERNEL-1:0][c2d_pkg::REG_BITS-1:0]   coef_rows,
  output logic [c2d_pkg::VALUE_BITS-1:0]                      sum
);
  import c2d_pkg::*;

  localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;

  logic signed [PIXEL_BITS-1:0] win  [KERNEL][KERNEL];
  logic signed [COEF_BITS-1:0]  coef [KERNEL][KERNEL];
  logic signed [PROD_BITS-1:0]  prod [KERNEL][KERNEL];
  logic [VALUE_BITS-1:0]        rsum [KERNEL];

  always_comb begin
    for (int k = 0; k < KERNEL; k++) begin
      for (int l = 0; l < KERNEL; l++) begin
        coef[k][l] = coef_rows[k][COEF_BITS*l +: COEF_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KERNEL; k++) begin
        for (int l = 0; l < KERNEL; l++) begin
          win[k][l] <= '0;
        end
      end
    end else if (win_en) begin
      for (int k = 0; k < KERNEL; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= col_top;
      win[1][2] <= col_mid;
      win[2][2] <= col_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < KERNEL; k++) begin
        for (int l = 0; l < KERNEL; l++) begin
          prod[k][l] <= win[k][l] * coef[k][l];
        end
        rsum[k] <= VALUE_BITS'(prod[k][0]) + VALUE_BITS'(prod[k][1])
                 + VALUE_BITS'(prod[k][2]);
      end
    end
  end

  assign sum = rsum[0] + rsum[1] + rsum[2];

endmodule

>>> rtl/core/conv2d_3x3_stream.sv
// Top level of the streaming 3x3 convolution: configuration, pipeline control, output register.
// Takes one signed pixel per clock in raster order unless stalled (s_tuser marks the first
// pixel of a frame) and returns the filtered value for the position one row and one column
// behind it, so the first frame_width+1 pixels of a frame give no result and the last result
// carries m_tlast. That rate is set by the single-port-pair line store that is read and
// written once per pixel; a pixel passes the a_v, v_w, v_p and v_s registers before m_tvalid.
// The whole pipeline holds while an output transaction waits. The line store is MAX_WIDTH
// words of two pixels and is not cleared after reset; border outputs (first row, first and
// last column) are zero. Write configuration only while no transaction is in flight.
module conv2d_3x3_stream #(
  parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = c2d_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [c2d_pkg::IN_DATA_BITS-1:0]    s_tdata,   // pixel[15:0]
  input  logic                                s_tuser,   // frame_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [c2d_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // value[31:0], out_row[47:32],
                                                         // out_col[57:48], zero[63:58]
  output logic                                m_tlast,
  input  logic                                cfg_wr_en,
  input  logic [c2d_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [c2d_pkg::REG_BITS-1:0]        cfg_data
);
  import c2d_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WB       = COL_BITS + 1;
  localparam int W_RST    = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

  logic [KERNEL-1:0][REG_BITS-1:0] coef_rows;
  logic [WB-1:0]                   width;
  logic [ROW_BITS-1:0]             height;
  logic [31:0]                     w_req;
  logic [31:0]                     w_sat;
  logic [ROW_BITS-1:0]             h_sat;

  logic                            adv;
  logic                            acc;
  logic                            a_v;
  logic                            v_w;
  logic                            v_p;
  logic                            v_s;
  meta_t                           meta_a;
  meta_t                           meta_w;
  meta_t                           meta_p;
  meta_t                           meta_s;
  logic [COL_BITS-1:0]             cur_col;
  logic signed [PIXEL_BITS-1:0]    pixel_in;
  logic signed [PIXEL_BITS-1:0]    col_top;
  logic signed [PIXEL_BITS-1:0]    col_mid;
  logic signed [PIXEL_BITS-1:0]    col_bot;
  logic [VALUE_BITS-1:0]           sum;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign acc      = s_tvalid && adv;
  assign pixel_in = s_tdata[PIXEL_BITS-1:0];

  always_comb begin
    w_req = 32'(cfg_data[FW_BITS-1:0]);
    if (w_req < 32'(WIDTH_MIN)) begin
      w_sat = 32'(WIDTH_MIN);
    end else if (w_req > 32'(MAX_WIDTH)) begin
      w_sat = 32'(MAX_WIDTH);
    end else begin
      w_sat = w_req;
    end
    h_sat = (cfg_data[ROW_BITS-1:0] < ROW_BITS'(HEIGHT_MIN)) ? ROW_BITS'(HEIGHT_MIN)
                                                             : cfg_data[ROW_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_rows <= '0;
      width     <= WB'(W_RST);
      height    <= ROW_BITS'(HEIGHT_MIN);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COEF_TOP: coef_rows[0] <= cfg_data;
        REG_COEF_MID: coef_rows[1] <= cfg_data;
        REG_COEF_BOT: coef_rows[2] <= cfg_data;
        REG_WIDTH:    width        <= w_sat[WB-1:0];
        REG_HEIGHT:   height       <= h_sat;
        default: ;
      endcase
    end
  end

  c2d_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .frame_start (s_tuser),
    .width       (width),
    .height      (height),
    .cur_col     (cur_col),
    .meta        (meta_a)
  );

  c2d_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .rd_addr (cur_col),
    .pixel   (pixel_in),
    .a_valid (a_v),
    .adv     (adv),
    .col_top (col_top),
    .col_mid (col_mid),
    .col_bot (col_bot)
  );

  c2d_mac #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .win_en    (a_v && adv),
    .adv       (adv),
    .col_top   (col_top),
    .col_mid   (col_mid),
    .col_bot   (col_bot),
    .coef_rows (coef_rows),
    .sum       (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v      <= 1'b0;
      v_w      <= 1'b0;
      v_p      <= 1'b0;
      v_s      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      a_v      <= s_tvalid;
      v_w      <= a_v;
      v_p      <= v_w;
      v_s      <= v_p;
      m_tvalid <= v_s && meta_s.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_w  <= meta_a;
      meta_p  <= meta_w;
      meta_s  <= meta_p;
      m_tdata <= {{OUT_PAD{1'b0}}, meta_s.col, meta_s.row,
                  meta_s.border ? {VALUE_BITS{1'b0}} : sum};
      m_tlast <= meta_s.last;
    end
  end

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v_s))
    else $error("result appeared without an item in the last pipeline stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (v_s && !s_tready) |=> v_s)
    else $error("pipeline item lost during output stall");

  a_first_row_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[ROW_LSB +: ROW_BITS] == '0)) |-> (m_tdata[VALUE_BITS-1:0] == '0))
    else $error("nonzero value on the first output row");

endmodule
